/* src/pds_pkg.sv */
// shared constants for the pixel clock divider search block
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

   // default reference divider range
   localparam int N_FIRST_DEF = 2;
   localparam int N_LAST_DEF  = 32;

   // field widths
   localparam int PERIOD_W = 27;
   localparam int WORD_W   = 16;
   localparam int REF_W    = 14;
   localparam int FREQ_W   = 16;
   localparam int NDIV_W   = 6;
   localparam int FDBL_W   = 20;  // doubled frequency stays below 2^20
   localparam int POST_W   = 5;   // at most 19 doublings
   localparam int SUB_W    = 28;  // shared subtractor operand width

   // picoseconds to 0.01 MHz scale and fixed result codes
   localparam logic [PERIOD_W-1:0] PS_SCALE  = 27'd100000000;
   localparam logic [WORD_W-1:0]   ZERO_WORD = 16'h00FF;

   // configuration register indexes
   localparam logic [1:0] CSR_REF_FREQ = 2'd0;
   localparam logic [1:0] CSR_MIN_FREQ = 2'd1;
   localparam logic [1:0] CSR_MAX_FREQ = 2'd2;

   // configuration reset values
   localparam logic [REF_W-1:0]  REF_FREQ_RST = 14'd1432;
   localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 16'd8000;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 16'd15938;

endpackage

`default_nettype wire

/* src/pll_divider_search_att408_core.sv */
// pixel clock synthesizer program word search, top level
//
// Usage:
//   A request on the req_ channel carries a pixel clock period in picoseconds.
//   One response on the rsp_ channel carries the 16-bit program word:
//   feedback count in bits 15:8, post divider code in 7:6, reference divider N
//   in 5:0. A zero period, or one that gives zero frequency, returns 0x00FF.
//   The csr_ port writes ref_freq (0), min_freq (1) and max_freq (2); write it
//   only while no request is in flight.
// Sequencing:
//   One shared subtractor does the subtractions under a sequencer: restoring
//   division for the frequency, doubling, then for each reference divider
//   multiply, subtract, range check, 8-step quotient and update. A request is
//   taken only in idle, so req_tready is low until its word is handed on.
// Reset and stalls:
//   Reset clears the sequencer and the response slot and loads the register
//   defaults. The response is held in an output register; a new request is
//   taken while it waits, and a finished word waits until the slot is free.
`timescale 1ns / 1ps
`default_nettype none

module pll_divider_search_att408_core
   import pds_pkg::*;
#(
   parameter int N_FIRST = N_FIRST_DEF,
   parameter int N_LAST  = N_LAST_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [26:0] period_ps
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] program_word
   // configuration port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   localparam logic [NDIV_W-1:0] NF = NDIV_W'(N_FIRST);
   localparam logic [NDIV_W-1:0] NL = NDIV_W'(N_LAST);

   typedef enum logic [3:0] {
      S_IDLE, S_FDIV, S_CLAMP, S_DOUBLE, S_NMUL, S_NSUB, S_NCHK, S_QDIV, S_NUPD, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [REF_W-1:0]    ref_ff, ref_in;
   logic [FREQ_W-1:0]   min_ff, min_in;
   logic [FREQ_W-1:0]   max_ff, max_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] quo_ff, quo_in;
   logic [PERIOD_W-1:0] prod_ff, prod_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [FDBL_W-1:0]   f_ff, f_in;
   logic [POST_W-1:0]   post_ff, post_in;
   logic [NDIV_W-1:0]   n_ff, n_in;
   logic [REF_W-1:0]    best_ff, best_in;
   logic                have_best_ff, have_best_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;

   // shared subtractor
   logic [SUB_W-1:0]    sub_a, sub_b;
   logic [SUB_W:0]      sub_res;
   logic                borrow;
   logic [SUB_W-1:0]    diff;

   // clamp helpers
   logic [PERIOD_W-1:0] clamp_lo, clamp_hi;

   // next-divider decision
   logic                last_n;

   assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow  = sub_res[SUB_W];
   assign diff    = sub_res[SUB_W-1:0];
   assign last_n  = (n_ff >= NL);

   assign clamp_lo = (quo_ff < {11'b0, min_ff}) ? {11'b0, min_ff} : quo_ff;
   assign clamp_hi = (clamp_lo > {11'b0, max_ff}) ? {11'b0, max_ff} : clamp_lo;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // subtractor operand selection
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      unique case (state_ff)
         S_FDIV: begin
            sub_a = {rem_ff, PS_SCALE[cnt_ff]};
            sub_b = {1'b0, period_ff};
         end
         S_DOUBLE: begin
            sub_a = {8'b0, f_ff};
            sub_b = {9'b0, min_ff, 3'b0};
         end
         S_NSUB: begin
            sub_a = {1'b0, prod_ff};
            sub_b = {13'b0, ref_ff, 1'b0};
         end
         S_NCHK: begin
            sub_a = {1'b0, rem_ff};
            sub_b = {6'b0, ref_ff, 8'b0};
         end
         S_QDIV: begin
            sub_a = {1'b0, rem_ff};
            sub_b = SUB_W'({14'b0, ref_ff} << cnt_ff[2:0]);
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ref_in       = ref_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      period_in    = period_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      f_in         = f_ff;
      post_in      = post_ff;
      n_in         = n_ff;
      best_in      = best_ff;
      have_best_in = have_best_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // response slot drains
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_REF_FREQ: ref_in = csr_wdata[REF_W-1:0];
            CSR_MIN_FREQ: min_in = csr_wdata;
            CSR_MAX_FREQ: max_in = csr_wdata;
            default:      ref_in = ref_ff;
         endcase
      end

      unique case (state_ff)
         // take a request
         S_IDLE: begin
            if (req_tvalid) begin
               period_in = req_tdata[PERIOD_W-1:0];
               rem_in    = '0;
               quo_in    = '0;
               cnt_in    = 5'(PERIOD_W - 1);
               if (req_tdata[PERIOD_W-1:0] == '0) begin
                  word_in  = ZERO_WORD;
                  state_in = S_OUT;
               end else begin
                  state_in = S_FDIV;
               end
            end
         end
         // restoring division of the picosecond scale by the period
         S_FDIV: begin
            rem_in = borrow ? sub_a[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
            quo_in = {quo_ff[PERIOD_W-2:0], ~borrow};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = S_CLAMP;
            end
         end
         // clamp the frequency to the configured band
         S_CLAMP: begin
            post_in = '0;
            f_in    = clamp_hi[FDBL_W-1:0];
            if (quo_ff == '0) begin
               word_in  = ZERO_WORD;
               state_in = S_OUT;
            end else begin
               state_in = S_DOUBLE;
            end
         end
         // double until the frequency reaches eight times the lower clamp
         S_DOUBLE: begin
            if (borrow && (f_ff != '0)) begin
               f_in    = {f_ff[FDBL_W-2:0], 1'b0};
               post_in = post_ff + 5'd1;
            end else begin
               word_in      = {5'b0, post_ff, 6'b0};
               n_in         = NF;
               have_best_in = 1'b0;
               state_in     = (ref_ff == '0) ? S_OUT : S_NMUL;
            end
         end
         // feedback product for this divider
         S_NMUL: begin
            prod_in  = PERIOD_W'(({1'b0, n_ff} + 7'd2) * f_ff);
            state_in = S_NSUB;
         end
         // remove twice the reference
         S_NSUB: begin
            if (!borrow) begin
               rem_in   = diff[PERIOD_W-1:0];
               state_in = S_NCHK;
            end else if (last_n) begin
               state_in = S_OUT;
            end else begin
               n_in     = n_ff + 6'd1;
               state_in = S_NMUL;
            end
         end
         // quotient must fit in eight bits
         S_NCHK: begin
            if (borrow) begin
               quo_in   = '0;
               cnt_in   = 5'd7;
               state_in = S_QDIV;
            end else if (last_n) begin
               state_in = S_OUT;
            end else begin
               n_in     = n_ff + 6'd1;
               state_in = S_NMUL;
            end
         end
         // eight-step quotient by the reference
         S_QDIV: begin
            if (!borrow) begin
               rem_in = diff[PERIOD_W-1:0];
            end
            quo_in = {quo_ff[PERIOD_W-2:0], ~borrow};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = S_NUPD;
            end
         end
         // keep the last candidate with the smallest remainder
         S_NUPD: begin
            if (!have_best_ff || (rem_ff[REF_W-1:0] <= best_ff)) begin
               have_best_in = 1'b1;
               best_in      = rem_ff[REF_W-1:0];
               word_in      = {quo_ff[7:0], word_ff[7:6], n_ff};
            end
            if (last_n) begin
               state_in = S_OUT;
            end else begin
               n_in     = n_ff + 6'd1;
               state_in = S_NMUL;
            end
         end
         // hand the word to the response register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = word_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         have_best_ff <= 1'b0;
         ref_ff       <= REF_FREQ_RST;
         min_ff       <= MIN_FREQ_RST;
         max_ff       <= MAX_FREQ_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_best_ff <= have_best_in;
         ref_ff       <= ref_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
      period_ff   <= period_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      cnt_ff      <= cnt_in;
      f_ff        <= f_in;
      post_ff     <= post_in;
      n_ff        <= n_in;
      best_ff     <= best_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a zero period goes straight to the fixed word
   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata[PERIOD_W-1:0] == '0))
      |=> (state_ff == S_OUT) && (word_ff == ZERO_WORD))
      else $error("zero period did not give the fixed word");

   // quotient steps only run on a value below 256 references
   a_qdiv_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QDIV) |-> (rem_ff < {5'b0, ref_ff, 8'b0}))
      else $error("quotient step out of range");

   // a response is loaded only from the output state
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response loaded outside the output state");

   // doubling count stays within the frequency range
   a_post_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NMUL) |-> (post_ff <= 5'd19))
      else $error("too many frequency doublings");

endmodule

`default_nettype wire

/* bench/tb_pll_divider_search_att408_core.sv */
// testbench for the pixel clock program word search: directed table, then random periods
`timescale 1ns / 1ps

module tb_pll_divider_search_att408_core;
   import pds_pkg::*;

   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int DRAIN_CYCLES    = 500;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 62;
   localparam logic [WORD_W-1:0] POST_STEP = 16'h0040;
   localparam int FB_COUNT_MAX = 255;
   localparam logic [WORD_W-1:0] NO_FB_REF_ZERO = 16'h00C0;  // three doublings, no divider

   // one row of the directed table
   typedef struct {
      logic [REF_W-1:0]    ref_f;
      logic [FREQ_W-1:0]   lo_f;
      logic [FREQ_W-1:0]   hi_f;
      logic [PERIOD_W-1:0] period;
      bit                  typed;
      logic [WORD_W-1:0]   word;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = CSR_REF_FREQ;
   logic [15:0] csr_wdata  = '0;

   // bench copy of the configuration registers
   logic [REF_W-1:0]  cfg_ref_freq = REF_FREQ_RST;
   logic [FREQ_W-1:0] cfg_min_freq = MIN_FREQ_RST;
   logic [FREQ_W-1:0] cfg_max_freq = MAX_FREQ_RST;

   logic [WORD_W-1:0] pending_words[$];
   logic [WORD_W-1:0] rsp_expect;
   dir_row_type       dir_rows[$];
   int                send_idle_pct = 17;
   int                rcv_idle_pct  = 55;
   int                fail_count    = 0;
   int                quiet_cycles  = 0;

   always #5 clock = ~clock;

   pll_divider_search_att408_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // expected program word for one period under the current registers
   function automatic logic [WORD_W-1:0] predict_program_word(input logic [PERIOD_W-1:0] period);
      logic [63:0]       freq;
      logic [63:0]       prod;
      logic [63:0]       num;
      logic [63:0]       fb_count;
      logic [63:0]       rem;
      logic [63:0]       best_rem;
      logic [WORD_W-1:0] word;
      int                n;
      if (period == '0) return ZERO_WORD;
      freq = 64'(PS_SCALE) / 64'(period);
      if (freq == 0) return ZERO_WORD;
      // lower clamp first, then upper
      if (freq < 64'(cfg_min_freq)) freq = 64'(cfg_min_freq);
      if (freq > 64'(cfg_max_freq)) freq = 64'(cfg_max_freq);
      word = '0;
      while (freq < (64'(cfg_min_freq) << 3)) begin
         freq = freq << 1;
         word = word + POST_STEP;
      end
      if (cfg_ref_freq == '0) return word;
      best_rem = 64'hFFFF;
      // the first divider is always tried, even on an empty range
      for (n = N_FIRST_DEF; n <= N_LAST_DEF || n == N_FIRST_DEF; n++) begin
         prod = 64'(n + 2) * freq;
         if (prod >= (64'(cfg_ref_freq) << 1)) begin
            num      = prod - (64'(cfg_ref_freq) << 1);
            fb_count = num / 64'(cfg_ref_freq);
            rem      = num % 64'(cfg_ref_freq);
            if (fb_count <= 64'(FB_COUNT_MAX) && rem <= best_rem) begin
               best_rem = rem;
               word     = {fb_count[7:0], word[7:6], 6'(n)};
            end
         end
      end
      return word;
   endfunction

   // period mix weighted towards frequencies inside the usual clamp window
   function automatic logic [PERIOD_W-1:0] random_period();
      int          pick;
      logic [31:0] raw;
      pick = $urandom_range(99);
      raw  = $urandom();
      if (pick < 60) return PERIOD_W'($urandom_range(50000, 1000));
      else if (pick < 75) return raw[PERIOD_W-1:0];
      else if (pick < 85) return PERIOD_W'($urandom_range(999, 0));
      else if (pick < 95) return PERIOD_W'($urandom_range(100000000, 50001));
      else return PERIOD_W'($urandom_range(100000016, 99999984));
   endfunction

   // one request; waits for acceptance and queues the expected word
   task automatic send_period(input logic [PERIOD_W-1:0] period, input bit typed,
                              input logic [WORD_W-1:0] typed_word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(32-PERIOD_W){1'b0}}, period};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_words.push_back(typed ? typed_word : predict_program_word(period));
   endtask

   // register writes once the block has drained
   task automatic apply_config(input logic [REF_W-1:0] ref_f, input logic [FREQ_W-1:0] lo_f,
                               input logic [FREQ_W-1:0] hi_f);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_REF_FREQ;
      csr_wdata <= {{(16-REF_W){1'b0}}, ref_f};
      @(posedge clock);
      csr_addr  <= CSR_MIN_FREQ;
      csr_wdata <= lo_f;
      @(posedge clock);
      csr_addr  <= CSR_MAX_FREQ;
      csr_wdata <= hi_f;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_ref_freq = ref_f;
      cfg_min_freq = lo_f;
      cfg_max_freq = hi_f;
   endtask

   // random register setting: mostly plausible, some extremes and crossed bounds
   task automatic random_config();
      int                pick;
      logic [REF_W-1:0]  ref_f;
      logic [FREQ_W-1:0] lo_f;
      logic [FREQ_W-1:0] hi_f;
      logic [FREQ_W-1:0] swap_f;
      pick = $urandom_range(99);
      if (pick < 10) ref_f = 14'd1;
      else if (pick < 20) ref_f = 14'd16383;
      else if (pick < 70) ref_f = REF_W'($urandom_range(2000, 500));
      else ref_f = REF_W'($urandom_range(16383, 1));
      pick = $urandom_range(99);
      if (pick < 50) begin
         lo_f = FREQ_W'($urandom_range(10000, 1000));
         hi_f = FREQ_W'($urandom_range(int'(lo_f) + 20000, int'(lo_f)));
      end else begin
         lo_f = FREQ_W'($urandom_range(65535, 1));
         hi_f = FREQ_W'($urandom_range(65535, 1));
         // keep the bounds ordered unless a crossed setting is wanted
         if (pick < 85 && lo_f > hi_f) begin
            swap_f = lo_f;
            lo_f   = hi_f;
            hi_f   = swap_f;
         end
      end
      apply_config(ref_f, lo_f, hi_f);
   endtask

   // response side: random back-pressure and in-order comparison
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected program word, expected none, actual %h", $time,
                        rsp_tdata);
               fail_count++;
            end else begin
               rsp_expect = pending_words.pop_front();
               if (rsp_tdata !== rsp_expect) begin
                  $display("%0t: program word mismatch, expected %h, actual %h", $time,
                           rsp_expect, rsp_tdata);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero frequency cases, clamp edges, typical modes
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd0, 1'b1, ZERO_WORD});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd100000001, 1'b1,
                           ZERO_WORD});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'h7FFFFFF, 1'b1,
                           ZERO_WORD});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd100000000, 1'b0, '0});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd1, 1'b0, '0});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd12500, 1'b0, '0});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd6274, 1'b0, '0});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd10000, 1'b0, '0});
      dir_rows.push_back('{REF_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST, 27'd39722, 1'b0, '0});
      // zero reference: post divider bits only
      dir_rows.push_back('{14'd0, MIN_FREQ_RST, MAX_FREQ_RST, 27'd10000, 1'b1, NO_FB_REF_ZERO});
      dir_rows.push_back('{14'd0, MIN_FREQ_RST, MAX_FREQ_RST, 27'd0, 1'b1, ZERO_WORD});
      // smallest reference and widest window: no qualifying feedback count at the top
      dir_rows.push_back('{14'd1, 16'd1, 16'd65535, 27'd1, 1'b0, '0});
      dir_rows.push_back('{14'd1, 16'd1, 16'd65535, 27'd100000000, 1'b0, '0});
      dir_rows.push_back('{14'd1, 16'd1, 16'd65535, 27'd5000, 1'b0, '0});
      // largest reference and bounds
      dir_rows.push_back('{14'd16383, 16'd65535, 16'd65535, 27'd1000, 1'b0, '0});
      dir_rows.push_back('{14'd16383, 16'd65535, 16'd65535, 27'h7FFFFFF, 1'b1, ZERO_WORD});
      // crossed bounds: upper clamp wins, most doublings
      dir_rows.push_back('{REF_FREQ_RST, 16'd65535, 16'd1, 27'd20000, 1'b0, '0});
      // product never reaches twice the reference
      dir_rows.push_back('{14'd16383, 16'd1, 16'd1, 27'd50000, 1'b0, '0});

      foreach (dir_rows[i]) begin
         if (dir_rows[i].ref_f != cfg_ref_freq || dir_rows[i].lo_f != cfg_min_freq ||
             dir_rows[i].hi_f != cfg_max_freq)
            apply_config(dir_rows[i].ref_f, dir_rows[i].lo_f, dir_rows[i].hi_f);
         send_period(dir_rows[i].period, dir_rows[i].typed, dir_rows[i].word);
      end

      // random phases: receiver idles more, then sender, then neither
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase * 3 / RANDOM_PHASES)
            0: begin
               send_idle_pct = 17;
               rcv_idle_pct  = 55;
            end
            1: begin
               send_idle_pct = 55;
               rcv_idle_pct  = 17;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         random_config();
         for (int k = 0; k < ITEMS_PER_PHASE; k++)
            send_period(random_period(), 1'b0, '0);
      end

      // drain and final verdict
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
